// ----- sv/stks_pkg.sv -----
// ----------------------------------------------------------------------------
// stks_pkg
// Types and codes shared by the static table key search block.
// ----------------------------------------------------------------------------
package stks_pkg;

    localparam int POS_W = 8;
    localparam int KEY_W = 32;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_SEQ   = 2'd1;
    localparam logic [1:0] MODE_BIN   = 2'd2;

    typedef struct packed {
        logic [1:0]              mode;
        logic [POS_W-1:0]        slot;
        logic signed [KEY_W-1:0] key_value;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             found;
    } t_res_item;

    // Key memory access, addressed by table position (1-based)
    typedef struct packed {
        logic             wr_en;
        logic [POS_W-1:0] wr_pos;
        logic [KEY_W-1:0] wr_key;
        logic             rd_en;
        logic [POS_W-1:0] rd_pos;
    } t_mem_req;

endpackage

// ----- sv/static_table_key_search.sv -----
// ----------------------------------------------------------------------------
// static_table_key_search
// Key table with sequential and binary search over positions 1..entry_count.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid / o_stall carries i_in (mode, slot, key_value).
//   A transfer happens on a rising edge with i_valid high and o_stall low.
//   A write item stores key_value at slot and gives no result;
//   slot 0, slots beyond the table and mode 3 are dropped.
//   A sequential search compares one table entry per cycle, set by the
//   single read port of the key memory, from position entry_count down;
//   entry_count is capped at TABLE_DEPTH, so at most TABLE_DEPTH entries
//   are compared.
//   A binary search probes one entry per cycle. An empty table answers
//   not found without a table read.
//   The next item is taken the cycle after the result enters the output
//   register; o_stall stays high from a search's transfer until then.
//   Output channel o_valid / i_stall carries o_out (position, found); while
//   i_stall is high a valid result holds and a finished search waits in the
//   sequencer, keeping o_stall high.
//   Reset clears entry_count to 0 and empties the pipeline; table contents
//   are undefined until written. i_cfg_we writes entry_count from i_cfg_data;
//   the user must assert it only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module static_table_key_search #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [stks_pkg::POS_W-1:0]  i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  stks_pkg::t_in_item          i_in,
    output logic                        o_valid,
    input  logic                        i_stall,
    output stks_pkg::t_res_item         o_out
);

    stks_pkg::t_mem_req          mem_req;
    logic [stks_pkg::KEY_W-1:0]  rd_key;

    stks_key_mem #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_key_mem (
        .i_clk    (i_clk),
        .i_req    (mem_req),
        .o_rd_key (rd_key)
    );

    stks_search_ctl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_search_ctl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_in       (i_in),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out      (o_out),
        .o_req      (mem_req),
        .i_rd_key   (rd_key)
    );

endmodule

// ----- sv/stks_key_mem.sv -----
// ----------------------------------------------------------------------------
// stks_key_mem
// Key table: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module stks_key_mem #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic                        i_clk,
    input  stks_pkg::t_mem_req          i_req,
    output logic [stks_pkg::KEY_W-1:0]  o_rd_key
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int XW = (AW > stks_pkg::POS_W) ? AW : stks_pkg::POS_W;

    logic [stks_pkg::KEY_W-1:0] mem [TABLE_DEPTH];
    logic [stks_pkg::KEY_W-1:0] r_rd_key;
    logic [XW-1:0]              wr_ext;
    logic [XW-1:0]              rd_ext;
    logic [AW-1:0]              wr_addr;
    logic [AW-1:0]              rd_addr;

    // position p lives at address p - 1
    assign wr_ext  = XW'(i_req.wr_pos - stks_pkg::POS_W'(1));
    assign rd_ext  = XW'(i_req.rd_pos - stks_pkg::POS_W'(1));
    assign wr_addr = wr_ext[AW-1:0];
    assign rd_addr = rd_ext[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[wr_addr] <= i_req.wr_key;
        end
        if (i_req.rd_en) begin
            r_rd_key <= mem[rd_addr];
        end
    end

    assign o_rd_key = r_rd_key;

endmodule

// ----- sv/stks_search_ctl.sv -----
// ----------------------------------------------------------------------------
// stks_search_ctl
// Search sequencer: issues one table read a cycle while searching, compares, holds result.
// ----------------------------------------------------------------------------
module stks_search_ctl #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [stks_pkg::POS_W-1:0]    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  stks_pkg::t_in_item            i_in,
    output logic                          o_valid,
    input  logic                          i_stall,
    output stks_pkg::t_res_item           o_out,
    output stks_pkg::t_mem_req            o_req,
    input  logic [stks_pkg::KEY_W-1:0]    i_rd_key
);

    localparam int PW = stks_pkg::POS_W;
    localparam logic [PW-1:0] CNT_CAP = PW'((TABLE_DEPTH > 255) ? 255 : TABLE_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SEQ  = 4'b0010,
        S_BIN  = 4'b0100,
        S_HOLD = 4'b1000
    } t_state;

    t_state                 r_state, n_state;
    logic [PW-1:0]          r_count;
    logic [PW-1:0]          r_scan, n_scan;
    logic [PW:0]            r_low, n_low;
    logic [PW:0]            r_high, n_high;
    logic [PW-1:0]          r_mid, n_mid;
    logic signed [stks_pkg::KEY_W-1:0] r_key, n_key;
    stks_pkg::t_res_item    r_res, n_res;
    stks_pkg::t_res_item    r_out;
    logic                   r_out_valid;

    logic                   accept;
    logic                   out_free;
    logic [PW-1:0]          active;
    logic                   key_hit;
    logic                   key_below;
    logic [PW:0]            nl, nh;
    logic [PW+1:0]          mid_sum;
    logic [PW+1:0]          mid_sum0;

    assign o_stall  = (r_state != S_IDLE);
    assign accept   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign active   = (r_count > CNT_CAP) ? CNT_CAP : r_count;
    assign key_hit  = ($signed(i_rd_key) == r_key);
    assign key_below = (r_key < $signed(i_rd_key));
    assign mid_sum0 = (PW+2)'(1) + (PW+2)'(active);

    always_comb begin
        n_state = r_state;
        n_scan  = r_scan;
        n_low   = r_low;
        n_high  = r_high;
        n_mid   = r_mid;
        n_key   = r_key;
        n_res   = r_res;
        nl      = r_low;
        nh      = r_high;
        mid_sum = '0;
        o_req   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_key = i_in.key_value;
                    case (i_in.mode)
                        stks_pkg::MODE_WRITE: begin
                            o_req.wr_en  = (i_in.slot != '0) && (i_in.slot <= CNT_CAP);
                            o_req.wr_pos = i_in.slot;
                            o_req.wr_key = i_in.key_value;
                        end
                        stks_pkg::MODE_SEQ: begin
                            n_scan = active;
                            if (active == '0) begin
                                n_res   = '0;
                                n_state = S_HOLD;
                            end else begin
                                o_req.rd_en  = 1'b1;
                                o_req.rd_pos = active;
                                n_state      = S_SEQ;
                            end
                        end
                        stks_pkg::MODE_BIN: begin
                            n_low  = (PW+1)'(1);
                            n_high = (PW+1)'(active);
                            n_mid  = PW'(mid_sum0 >> 1);
                            if (active == '0) begin
                                n_res   = '0;
                                n_state = S_HOLD;
                            end else begin
                                o_req.rd_en  = 1'b1;
                                o_req.rd_pos = PW'(mid_sum0 >> 1);
                                n_state      = S_BIN;
                            end
                        end
                        default: begin
                            // unused mode: drop the item
                        end
                    endcase
                end
            end
            S_SEQ: begin
                if (key_hit) begin
                    n_res.position = r_scan;
                    n_res.found    = 1'b1;
                    n_state        = S_HOLD;
                end else if (r_scan == PW'(1)) begin
                    n_res   = '0;
                    n_state = S_HOLD;
                end else begin
                    n_scan       = r_scan - PW'(1);
                    o_req.rd_en  = 1'b1;
                    o_req.rd_pos = r_scan - PW'(1);
                end
            end
            S_BIN: begin
                if (key_hit) begin
                    n_res.position = r_mid;
                    n_res.found    = 1'b1;
                    n_state        = S_HOLD;
                end else begin
                    if (key_below) begin
                        nh = (PW+1)'(r_mid) - (PW+1)'(1);
                    end else begin
                        nl = (PW+1)'(r_mid) + (PW+1)'(1);
                    end
                    n_low   = nl;
                    n_high  = nh;
                    mid_sum = (PW+2)'(nl) + (PW+2)'(nh);
                    n_mid   = PW'(mid_sum >> 1);
                    if (nl > nh) begin
                        n_res   = '0;
                        n_state = S_HOLD;
                    end else begin
                        o_req.rd_en  = 1'b1;
                        o_req.rd_pos = PW'(mid_sum >> 1);
                    end
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_scan      <= '0;
            r_low       <= '0;
            r_high      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_scan  <= n_scan;
            r_low   <= n_low;
            r_high  <= n_high;
            if (i_cfg_we) begin
                r_count <= i_cfg_data;
            end
            // load the held result, or release the one just taken
            if (r_state == S_HOLD && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mid <= n_mid;
        r_key <= n_key;
        r_res <= n_res;
        if (r_state == S_HOLD && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    a_scan_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEQ) |-> (r_scan != '0))
        else $error("sequential scan at position zero");

    a_bin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BIN) |-> (r_low <= r_high && (PW+1)'(r_mid) >= r_low
                                && (PW+1)'(r_mid) <= r_high))
        else $error("binary probe outside its range");

    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_in.mode == stks_pkg::MODE_SEQ || i_in.mode == stks_pkg::MODE_BIN))
        |=> (r_state != S_IDLE))
        else $error("search transfer did not start a search");

    a_hold_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOLD && out_free) |=> (r_out_valid && r_out == $past(r_res)))
        else $error("held result not moved to output");

    a_found_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.found == (r_out.position != '0)))
        else $error("found flag disagrees with position");

endmodule

// ----- tb/stks_search_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stks_search_checker
// Watches both channels and the count register of the key search block,
// predicts each search answer from its own copy of the table and compares
// every returned result with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module stks_search_checker #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [stks_pkg::POS_W-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  stks_pkg::t_in_item         i_in,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  stks_pkg::t_res_item        i_out,
    output int                         o_bad_results,
    output int                         o_open_results
);

    logic signed [stks_pkg::KEY_W-1:0] key_mem [1:TABLE_DEPTH];
    logic [stks_pkg::POS_W-1:0]        entry_count;
    stks_pkg::t_res_item               answers_due [$];
    int                                bad_results = 0;
    int                                open_results = 0;

    assign o_bad_results  = bad_results;
    assign o_open_results = open_results;

    function automatic stks_pkg::t_res_item search_answer(
        input logic [1:0] mode,
        input logic signed [stks_pkg::KEY_W-1:0] key);
        int                  n;
        int                  pos;
        int                  lo;
        int                  hi;
        int                  mid;
        stks_pkg::t_res_item ans;
        n   = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count);
        pos = 0;
        if (mode == stks_pkg::MODE_SEQ) begin
            // walk down from the top; first hit is the highest position
            pos = n;
            while (pos != 0 && key_mem[pos] != key) pos--;
        end else begin
            lo = 1;
            hi = n;
            while (lo <= hi && pos == 0) begin
                mid = (lo + hi) / 2;
                if (key_mem[mid] == key) pos = mid;
                else if (key < key_mem[mid]) hi = mid - 1;
                else lo = mid + 1;
            end
        end
        ans.position = pos[stks_pkg::POS_W-1:0];
        ans.found    = (pos != 0);
        return ans;
    endfunction

    task automatic flag_result(input string what);
        if (bad_results < 10) $display("%t: %s", $realtime, what);
        bad_results++;
    endtask

    always @(posedge i_clk) begin
        stks_pkg::t_res_item want;
        if (!i_rst_n) begin
            entry_count = '0;
            answers_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (answers_due.size() == 0) begin
                    flag_result($sformatf("unexpected result: position %0d found %0b",
                                          i_out.position, i_out.found));
                end else begin
                    want = answers_due.pop_front();
                    if (want.position !== i_out.position || want.found !== i_out.found)
                        flag_result($sformatf(
                            "result differs: position exp %0d got %0d, found exp %0b got %0b",
                            want.position, i_out.position, want.found, i_out.found));
                end
            end

            if (i_in_valid && !i_in_stall) begin
                case (i_in.mode)
                    stks_pkg::MODE_WRITE: begin
                        if (i_in.slot >= 1 && i_in.slot <= TABLE_DEPTH)
                            key_mem[i_in.slot] = i_in.key_value;
                    end
                    stks_pkg::MODE_SEQ, stks_pkg::MODE_BIN: begin
                        answers_due.push_back(search_answer(i_in.mode, i_in.key_value));
                    end
                    default: ;
                endcase
            end

            // a search taken on this edge still sees the old count
            if (i_cfg_we) entry_count = i_cfg_data;
        end
        open_results <= answers_due.size();
    end

endmodule

// ----- tb/tb_static_table_key_search.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_static_table_key_search
// Drives writes, sequential and binary searches into the key search block
// over a series of entry counts, with random gaps and output stalls, and
// reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_static_table_key_search;

    localparam int DEPTH          = 128;
    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE         = 10;
    localparam int END_WAIT       = 140;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 1200;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic signed [stks_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [stks_pkg::KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [stks_pkg::POS_W-1:0] i_cfg_data;
    logic                       i_valid;
    logic                       o_stall;
    stks_pkg::t_in_item         i_in;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    stks_pkg::t_res_item        o_out;

    int mismatches;
    int open_results;

    // stimulus-side copy of the table, used to aim keys at stored entries
    logic signed [stks_pkg::KEY_W-1:0] tbl [1:DEPTH];
    bit                                tbl_sorted = 1'b0;
    int                                cur_count = 0;
    int                                items_sent = 0;
    bit                                calm = 1'b0;
    int                                stall_left = 0;
    int                                quiet_cycles = 0;

    static_table_key_search #(
        .TABLE_DEPTH (DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_in       (i_in),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out      (o_out)
    );

    stks_search_checker #(
        .TABLE_DEPTH (DEPTH)
    ) search_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_in           (i_in),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_out          (o_out),
        .o_bad_results  (mismatches),
        .o_open_results (open_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 150);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else begin
            i_stall    <= !calm && ($urandom_range(0, 2) == 0);
            stall_left <= gap_len();
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one item and hold it until the transfer; valid stays high on return.
    task automatic send_item(input logic [1:0] mode,
                             input logic [stks_pkg::POS_W-1:0] slot,
                             input logic signed [stks_pkg::KEY_W-1:0] key);
        stks_pkg::t_in_item it;
        it.mode      = mode;
        it.slot      = slot;
        it.key_value = key;
        if (!calm && $urandom_range(0, 2) == 0) begin
            i_valid <= 1'b0;
            repeat (gap_len()) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in    <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
        if (mode == stks_pkg::MODE_WRITE && slot >= 1 && slot <= DEPTH) tbl[slot] = key;
    endtask

    // Stop sending and wait for every outstanding answer, then let writes settle.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (open_results != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_count(input logic [stks_pkg::POS_W-1:0] value);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_count = (value > DEPTH) ? DEPTH : int'(value);
    endtask

    // Fill every slot with non-decreasing keys from the lowest to the highest value.
    task automatic load_sorted();
        longint acc;
        acc = longint'(KEY_MIN);
        for (int p = 1; p <= DEPTH; p++) begin
            if (p == DEPTH) acc = longint'(KEY_MAX);
            else if (p > 1 && $urandom_range(0, 9) != 0) acc += $urandom_range(0, 33000000);
            send_item(stks_pkg::MODE_WRITE, p[stks_pkg::POS_W-1:0],
                      acc[stks_pkg::KEY_W-1:0]);
        end
        tbl_sorted = 1'b1;
    endtask

    // Keep the order: new key lies between its neighbors.
    task automatic sorted_write();
        int     s;
        longint lo;
        longint hi;
        longint k;
        s  = $urandom_range(1, DEPTH);
        lo = (s > 1) ? longint'(tbl[s-1]) : longint'(KEY_MIN);
        hi = (s < DEPTH) ? longint'(tbl[s+1]) : longint'(KEY_MAX);
        k  = lo + (longint'($urandom) % (hi - lo + 1));
        send_item(stks_pkg::MODE_WRITE, s[stks_pkg::POS_W-1:0], k[stks_pkg::KEY_W-1:0]);
    endtask

    task automatic scramble_write();
        int s;
        s = $urandom_range(1, DEPTH);
        if ($urandom_range(0, 1) == 0)
            send_item(stks_pkg::MODE_WRITE, s[stks_pkg::POS_W-1:0], $urandom);
        else
            send_item(stks_pkg::MODE_WRITE, s[stks_pkg::POS_W-1:0],
                      tbl[$urandom_range(1, DEPTH)]);
        tbl_sorted = 1'b0;
    endtask

    function automatic logic signed [stks_pkg::KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (cur_count > 0 && r < 60) return tbl[$urandom_range(1, cur_count)];
        if (cur_count > 0 && r < 75)
            return tbl[$urandom_range(1, cur_count)] + ($urandom_range(0, 1) ? 1 : -1);
        if (r < 90) return $urandom;
        case ($urandom_range(0, 3))
            0: return KEY_MIN;
            1: return KEY_MAX;
            2: return '0;
            default: return '1;
        endcase
    endfunction

    // Favor small tables; large ones make sequential scans long.
    function automatic logic [stks_pkg::POS_W-1:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 8'd0;
        if (r < 14) return 8'd1;
        if (r < 18) return 8'd2;
        if (r < 24) return 8'd128;
        if (r < 27) return 8'd255;
        if (r < 30) return stks_pkg::POS_W'($urandom_range(129, 254));
        if (r < 65) return stks_pkg::POS_W'($urandom_range(3, 12));
        return stks_pkg::POS_W'($urandom_range(13, 127));
    endfunction

    task automatic random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            send_item(stks_pkg::MODE_SEQ, stks_pkg::POS_W'($urandom_range(0, 255)),
                      pick_key());
        end else if (r < 80) begin
            send_item(stks_pkg::MODE_BIN, stks_pkg::POS_W'($urandom_range(0, 255)),
                      pick_key());
        end else if (r < 90) begin
            if (tbl_sorted) sorted_write();
            else scramble_write();
        end else if (r < 95) begin
            send_item(MODE_UNUSED, stks_pkg::POS_W'($urandom_range(0, 255)), $urandom);
        end else begin
            // slot zero or past the table end: dropped by the block
            if ($urandom_range(0, 1) == 0)
                send_item(stks_pkg::MODE_WRITE, 8'd0, $urandom);
            else
                send_item(stks_pkg::MODE_WRITE,
                          stks_pkg::POS_W'($urandom_range(DEPTH + 1, 255)), $urandom);
        end
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_data <= '0;
        i_valid    <= 1'b0;
        i_in       <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table after reset
        send_item(stks_pkg::MODE_SEQ, 8'd0, '0);
        send_item(stks_pkg::MODE_BIN, 8'hff, KEY_MIN);
        send_item(stks_pkg::MODE_SEQ, 8'd1, KEY_MAX);
        send_item(MODE_UNUSED, 8'hff, '1);

        load_sorted();
        set_count(8'd128);
        send_item(stks_pkg::MODE_SEQ, 8'd0, tbl[1]);
        send_item(stks_pkg::MODE_BIN, 8'd0, tbl[1]);
        send_item(stks_pkg::MODE_SEQ, 8'd0, tbl[DEPTH]);
        send_item(stks_pkg::MODE_BIN, 8'd0, tbl[DEPTH]);
        send_item(stks_pkg::MODE_BIN, 8'd0, tbl[DEPTH/2]);
        send_item(stks_pkg::MODE_WRITE, 8'd0, 32'sd12345);
        send_item(stks_pkg::MODE_WRITE, 8'd129, 32'sd12345);
        send_item(stks_pkg::MODE_WRITE, 8'hff, 32'sd12345);
        send_item(stks_pkg::MODE_SEQ, 8'd0, 32'sd12345);
        send_item(stks_pkg::MODE_BIN, 8'd0, 32'sd12345);

        // count past the table end saturates to the full table
        set_count(8'hff);
        send_item(stks_pkg::MODE_SEQ, 8'd0, tbl[DEPTH]);
        send_item(stks_pkg::MODE_BIN, 8'd0, tbl[DEPTH]);
        send_item(stks_pkg::MODE_SEQ, 8'd0, '1);

        set_count(8'd1);
        send_item(stks_pkg::MODE_SEQ, 8'd0, tbl[1]);
        send_item(stks_pkg::MODE_BIN, 8'd0, tbl[1]);
        send_item(stks_pkg::MODE_BIN, 8'd0, tbl[2]);

        while (items_sent < RANDOM_ITEMS) begin
            calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) < 8) begin
                if (!tbl_sorted) load_sorted();
            end else begin
                repeat ($urandom_range(4, 16)) scramble_write();
            end
            set_count(pick_count());
            repeat ($urandom_range(20, 80)) begin
                if (items_sent < RANDOM_ITEMS) random_item();
            end
        end

        calm = 1'b0;
        drain();
        repeat (END_WAIT) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- static_table_key_search.f -----
sv/stks_pkg.sv
sv/stks_key_mem.sv
sv/stks_search_ctl.sv
sv/static_table_key_search.sv
tb/stks_search_checker.sv
tb/tb_static_table_key_search.sv
